/* design/env_sensor_compensation_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the environmental sensor compensation block
// Shared immediate-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/esc_pkg.sv */
// ----------------------------------------------------------------------------
// Environmental sensor compensation package
// Shared constants, register codes, types and arithmetic helpers.
// ----------------------------------------------------------------------------
package esc_pkg;

   // Width of the pipelined divider.
   localparam int EscDivW = 64;

   // Compensation constants.
   localparam logic [63:0] FineOffsetP = 64'd128000;
   localparam logic [63:0] AdcFull     = 64'd1048576;
   localparam logic [63:0] DivScale    = 64'd3125;
   localparam logic [63:0] FineOffsetH = 64'd76800;
   localparam logic [63:0] HumRound    = 64'd16384;
   localparam logic [63:0] HumBias     = 64'd2097152;
   localparam logic [63:0] HumRound2   = 64'd8192;
   localparam logic [63:0] HumBias2    = 64'd32768;
   localparam logic [63:0] TempRound   = 64'd128;
   localparam logic [63:0] PressBias   = 64'h0000_8000_0000_0000;

   localparam logic signed [63:0] TempMin   = -64'sd65536;
   localparam logic signed [63:0] TempMax   = 64'sd65535;
   localparam logic signed [63:0] HumMax    = 64'sd419430400;
   localparam logic [16:0]        TempMinOut = 17'h10000;
   localparam logic [16:0]        TempMaxOut = 17'h0FFFF;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_TEMP_CAL   = 3'd0,
      CSR_PRESS_A    = 3'd1,
      CSR_PRESS_B    = 3'd2,
      CSR_PRESS_NINE = 3'd3,
      CSR_HUM_CAL    = 3'd4
   } csr_index_type;

   // Partial products of a 64-bit wrapping multiply.
   typedef struct packed {
      logic [63:0] ll;
      logic [31:0] cr;
   } mulp_type;

   // Results that ride alongside the division.
   typedef struct packed {
      logic        neg;
      logic        zero;
      logic [16:0] temp;
      logic [16:0] hum;
   } side_type;

   // First half of a multiply modulo 2^64: low product and cross terms.
   function automatic mulp_type mul_part(input logic [63:0] a, input logic [63:0] b);
      mulp_type p;
      p.ll = a[31:0] * b[31:0];
      p.cr = a[31:0] * b[63:32] + a[63:32] * b[31:0];
      return p;
   endfunction

   // Second half: fold the cross terms into the upper word.
   function automatic logic [63:0] mul_join(input mulp_type p);
      return p.ll + {p.cr, 32'd0};
   endfunction

   // Arithmetic right shift of a 64-bit word.
   function automatic logic [63:0] asr(input logic [63:0] v, input int unsigned n);
      return 64'($signed(v) >>> n);
   endfunction

endpackage

/* design/esc_div.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with side data carried along.
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_assert.svh"

module esc_div #(
   parameter int Width = 64,
   parameter int SideW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [Width-1:0] in_num,
   input  logic [Width-1:0] in_den,
   input  logic [SideW-1:0] in_side,
   output logic             out_valid,
   output logic [Width-1:0] out_quot,
   output logic [SideW-1:0] out_side
);
   import esc_pkg::*;

   logic [Width-1:0] rem_ff  [Width];
   logic [Width-1:0] nq_ff   [Width];
   logic [Width-1:0] den_ff  [Width];
   logic [SideW-1:0] side_ff [Width];
   logic [Width-1:0] v_ff;

   // One stage per quotient bit, from the most significant down.
   for (genvar g = 0; g < Width; g++) begin : g_stage
      logic [Width-1:0] r_src;
      logic [Width-1:0] n_src;
      logic [Width-1:0] d_src;
      logic [SideW-1:0] s_src;
      logic             v_src;
      logic [Width:0]   trial;
      logic [Width:0]   diff;
      logic             ge;

      if (g == 0) begin : g_first
         assign r_src = '0;
         assign n_src = in_num;
         assign d_src = in_den;
         assign s_src = in_side;
         assign v_src = in_valid;
      end else begin : g_rest
         assign r_src = rem_ff[g-1];
         assign n_src = nq_ff[g-1];
         assign d_src = den_ff[g-1];
         assign s_src = side_ff[g-1];
         assign v_src = v_ff[g-1];
      end

      // Shift in the next dividend bit and try the subtraction.
      assign trial = {r_src, n_src[Width-1]};
      assign diff  = trial - {1'b0, d_src};
      assign ge    = (trial >= {1'b0, d_src});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= ge ? diff[Width-1:0] : trial[Width-1:0];
            nq_ff[g]   <= {n_src[Width-2:0], ge};
            den_ff[g]  <= d_src;
            side_ff[g] <= s_src;
         end
      end
   end

   assign out_valid = v_ff[Width-1];
   assign out_quot  = nq_ff[Width-1];
   assign out_side  = side_ff[Width-1];

   // The final remainder is always below the divisor.
   `ESC_ASSERT_NOW(a_rem_below_den, clock, reset, v_ff[Width-1],
      rem_ff[Width-1] < den_ff[Width-1], "remainder not below divisor")

   // An item offered while the pipeline advances enters the first stage.
   `ESC_ASSERT_NEXT(a_enter, clock, reset, en && in_valid, v_ff[0],
      "item lost at divider entry")

   // A frozen pipeline keeps its valid bits.
   `ESC_ASSERT_NEXT(a_freeze, clock, reset, !en, v_ff == $past(v_ff),
      "divider moved while stalled")

endmodule

/* design/env_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// Environmental sensor compensation
// The result passes through 90 register stages, the 64-stage divider among them.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Reset clears all valid bits and all calibration registers to zero.
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_assert.svh"

module env_sensor_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_press_msb,
   input  logic [7:0]  req_press_lsb,
   input  logic [7:0]  req_press_xlsb,
   input  logic [7:0]  req_temp_msb,
   input  logic [7:0]  req_temp_lsb,
   input  logic [7:0]  req_temp_xlsb,
   input  logic [7:0]  req_hum_msb,
   input  logic [7:0]  req_hum_lsb,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [16:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_q24_8,
   output logic [16:0] rsp_humidity_q22_10,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import esc_pkg::*;

   localparam int DivW = EscDivW;

   // ------------------------------------------------------------------
   // Calibration registers.
   // ------------------------------------------------------------------
   logic [47:0] temp_cal_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_nine_ff;
   logic [63:0] hum_cal_ff;
   logic        csr_write;
   csr_index_type csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = csr_index_type'(paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff   <= '0;
         press_a_ff    <= '0;
         press_b_ff    <= '0;
         press_nine_ff <= '0;
         hum_cal_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_idx)
            CSR_TEMP_CAL:   temp_cal_ff   <= pwdata[47:0];
            CSR_PRESS_A:    press_a_ff    <= pwdata;
            CSR_PRESS_B:    press_b_ff    <= pwdata;
            CSR_PRESS_NINE: press_nine_ff <= pwdata[15:0];
            CSR_HUM_CAL:    hum_cal_ff    <= pwdata;
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (csr_idx)
         CSR_TEMP_CAL:   prdata = {16'd0, temp_cal_ff};
         CSR_PRESS_A:    prdata = press_a_ff;
         CSR_PRESS_B:    prdata = press_b_ff;
         CSR_PRESS_NINE: prdata = {48'd0, press_nine_ff};
         CSR_HUM_CAL:    prdata = hum_cal_ff;
         default:        prdata = '0;
      endcase
   end

   // Calibration words, extended to the 64-bit datapath.
   logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [63:0] h1, h2, h3, h4, h5, h6;

   assign t1 = {48'd0, temp_cal_ff[15:0]};
   assign t2 = 64'($signed(temp_cal_ff[31:16]));
   assign t3 = 64'($signed(temp_cal_ff[47:32]));
   assign p1 = {48'd0, press_a_ff[15:0]};
   assign p2 = 64'($signed(press_a_ff[31:16]));
   assign p3 = 64'($signed(press_a_ff[47:32]));
   assign p4 = 64'($signed(press_a_ff[63:48]));
   assign p5 = 64'($signed(press_b_ff[15:0]));
   assign p6 = 64'($signed(press_b_ff[31:16]));
   assign p7 = 64'($signed(press_b_ff[47:32]));
   assign p8 = 64'($signed(press_b_ff[63:48]));
   assign p9 = 64'($signed(press_nine_ff));
   assign h1 = {56'd0, hum_cal_ff[7:0]};
   assign h2 = 64'($signed(hum_cal_ff[23:8]));
   assign h3 = {56'd0, hum_cal_ff[31:24]};
   assign h4 = 64'($signed(hum_cal_ff[43:32]));
   assign h5 = 64'($signed(hum_cal_ff[55:44]));
   assign h6 = 64'($signed(hum_cal_ff[63:56]));

   // ------------------------------------------------------------------
   // Pipeline control: every stage advances when the result register
   // is empty or being taken.
   // ------------------------------------------------------------------
   logic        en;
   logic        rsp_valid_ff;
   logic [19:1] pv_ff;
   logic [6:1]  qv_ff;
   logic        div_out_valid;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff        <= '0;
         qv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         pv_ff        <= {pv_ff[18:1], req_valid};
         qv_ff        <= {qv_ff[5:1], div_out_valid};
         rsp_valid_ff <= qv_ff[6];
      end
   end

   // Raw samples.
   logic [63:0] adc_t;
   logic [19:0] adc_p;
   logic [15:0] adc_h;

   assign adc_t = {44'd0, req_temp_msb, req_temp_lsb, req_temp_xlsb[7:4]};
   assign adc_p = {req_press_msb, req_press_lsb, req_press_xlsb[7:4]};
   assign adc_h = {req_hum_msb, req_hum_lsb};

   // Payload registers of the stages ahead of the divider.
   logic [19:0] adcp_ff [1:10];
   logic [15:0] adch_ff [1:8];
   logic [16:0] temp_ff [7:18];
   logic [63:0] adiv_ff [12:18];
   logic [63:0] num_ff  [14:18];

   logic [63:0] s1_x_ff, s1_d_ff;
   mulp_type    s2_m1_ff, s2_m2_ff;
   logic [63:0] s3_at_ff, s3_dd_ff;
   mulp_type    s4_m3_ff;
   logic [63:0] s4_at_ff;
   logic [63:0] s5_fine_ff;
   logic [63:0] s6_tt_ff, s6_pa_ff, s6_hd_ff;
   mulp_type    s7_q1_ff, s7_q2_ff, s7_q3_ff, s7_hm5_ff, s7_hm6_ff, s7_hm3_ff;
   logic [63:0] s8_q1_ff, s8_q2_ff, s8_q3_ff, s8_hm5_ff, s8_h6t_ff, s8_h3t_ff;
   mulp_type    s9_r1_ff, s9_r2_ff, s9_hb_ff;
   logic [63:0] s9_ah_ff, s9_q2_ff, s9_q3_ff;
   logic [63:0] s10_b_ff, s10_aa_ff, s10_hb2_ff, s10_ah_ff;
   mulp_type    s11_pa2_ff, s11_hb3_ff;
   logic [63:0] s11_x_ff, s11_ah_ff;
   logic [63:0] s12_hb4_ff, s12_x_ff, s12_ah_ff;
   mulp_type    s13_nm_ff, s13_hdm_ff;
   logic [63:0] s14_hd_ff;
   mulp_type    s15_hs_ff;
   logic [63:0] s15_hd_ff;
   logic [63:0] s16_hs2_ff, s16_hd_ff;
   mulp_type    s17_hs3_ff;
   logic [63:0] s17_hd_ff;
   logic [63:0] s18_hfin_ff;
   side_type    s19_side_ff;
   logic [DivW-1:0] s19_mn_ff, s19_md_ff;

   // Stage-local combinational values.
   logic signed [63:0] tt_s, hfin_s, hum_clamp;
   logic [16:0] temp_sat;
   logic [63:0] fine5, ah_in, num18, adiv18;

   always_comb begin
      fine5 = s5_fine_ff + {s5_fine_ff[61:0], 2'b00} + TempRound;
      tt_s  = signed'(s6_tt_ff);
      if (tt_s < TempMin) begin
         temp_sat = TempMinOut;
      end else if (tt_s > TempMax) begin
         temp_sat = TempMaxOut;
      end else begin
         temp_sat = tt_s[16:0];
      end
      ah_in = asr(({48'd0, adch_ff[8]} << 14) - (h4 << 20) - s8_hm5_ff + HumRound, 15);
      hfin_s = signed'(s18_hfin_ff);
      if (hfin_s < 0) begin
         hum_clamp = '0;
      end else if (hfin_s > HumMax) begin
         hum_clamp = HumMax;
      end else begin
         hum_clamp = hfin_s;
      end
      num18  = num_ff[18];
      adiv18 = adiv_ff[18];
   end

   // Stages one to nineteen: fine temperature, pressure operands, humidity.
   always_ff @(posedge clock) begin
      if (en) begin
         // Fine temperature.
         s1_x_ff    <= (adc_t >> 3) - (t1 << 1);
         s1_d_ff    <= (adc_t >> 4) - t1;
         adcp_ff[1] <= adc_p;
         adch_ff[1] <= adc_h;
         for (int i = 2; i <= 10; i++) adcp_ff[i] <= adcp_ff[i-1];
         for (int i = 2; i <= 8; i++)  adch_ff[i] <= adch_ff[i-1];

         s2_m1_ff <= mul_part(s1_x_ff, t2);
         s2_m2_ff <= mul_part(s1_d_ff, s1_d_ff);

         s3_at_ff <= asr(mul_join(s2_m1_ff), 11);
         s3_dd_ff <= asr(mul_join(s2_m2_ff), 12);

         s4_m3_ff <= mul_part(s3_dd_ff, t3);
         s4_at_ff <= s3_at_ff;

         s5_fine_ff <= s4_at_ff + asr(mul_join(s4_m3_ff), 14);

         // Temperature result and the shared offsets.
         s6_tt_ff <= asr(fine5, 8);
         s6_pa_ff <= s5_fine_ff - FineOffsetP;
         s6_hd_ff <= s5_fine_ff - FineOffsetH;

         temp_ff[7] <= temp_sat;
         for (int i = 8; i <= 18; i++) temp_ff[i] <= temp_ff[i-1];
         s7_q1_ff  <= mul_part(s6_pa_ff, s6_pa_ff);
         s7_q2_ff  <= mul_part(s6_pa_ff, p5);
         s7_q3_ff  <= mul_part(s6_pa_ff, p2);
         s7_hm5_ff <= mul_part(h5, s6_hd_ff);
         s7_hm6_ff <= mul_part(s6_hd_ff, h6);
         s7_hm3_ff <= mul_part(s6_hd_ff, h3);

         s8_q1_ff  <= mul_join(s7_q1_ff);
         s8_q2_ff  <= mul_join(s7_q2_ff);
         s8_q3_ff  <= mul_join(s7_q3_ff);
         s8_hm5_ff <= mul_join(s7_hm5_ff);
         s8_h6t_ff <= asr(mul_join(s7_hm6_ff), 10);
         s8_h3t_ff <= asr(mul_join(s7_hm3_ff), 11) + HumBias2;

         s9_r1_ff <= mul_part(s8_q1_ff, p6);
         s9_r2_ff <= mul_part(s8_q1_ff, p3);
         s9_hb_ff <= mul_part(s8_h6t_ff, s8_h3t_ff);
         s9_ah_ff <= ah_in;
         s9_q2_ff <= s8_q2_ff;
         s9_q3_ff <= s8_q3_ff;

         s10_b_ff   <= mul_join(s9_r1_ff) + (s9_q2_ff << 17) + (p4 << 35);
         s10_aa_ff  <= PressBias + asr(mul_join(s9_r2_ff), 8) + (s9_q3_ff << 12);
         s10_hb2_ff <= asr(mul_join(s9_hb_ff), 10) + HumBias;
         s10_ah_ff  <= s9_ah_ff;

         s11_pa2_ff <= mul_part(s10_aa_ff, p1);
         s11_hb3_ff <= mul_part(s10_hb2_ff, h2);
         s11_x_ff   <= ((AdcFull - {44'd0, adcp_ff[10]}) << 31) - s10_b_ff;
         s11_ah_ff  <= s10_ah_ff;

         // Divisor and humidity product.
         adiv_ff[12] <= asr(mul_join(s11_pa2_ff), 33);
         for (int i = 13; i <= 18; i++) adiv_ff[i] <= adiv_ff[i-1];
         s12_hb4_ff <= asr(mul_join(s11_hb3_ff) + HumRound2, 14);
         s12_x_ff   <= s11_x_ff;
         s12_ah_ff  <= s11_ah_ff;

         s13_nm_ff  <= mul_part(s12_x_ff, DivScale);
         s13_hdm_ff <= mul_part(s12_ah_ff, s12_hb4_ff);

         num_ff[14] <= mul_join(s13_nm_ff);
         for (int i = 15; i <= 18; i++) num_ff[i] <= num_ff[i-1];
         s14_hd_ff  <= mul_join(s13_hdm_ff);

         // Humidity correction term.
         s15_hs_ff <= mul_part(asr(s14_hd_ff, 15), asr(s14_hd_ff, 15));
         s15_hd_ff <= s14_hd_ff;

         s16_hs2_ff <= asr(mul_join(s15_hs_ff), 7);
         s16_hd_ff  <= s15_hd_ff;

         s17_hs3_ff <= mul_part(s16_hs2_ff, h1);
         s17_hd_ff  <= s16_hd_ff;

         s18_hfin_ff <= s17_hd_ff - asr(mul_join(s17_hs3_ff), 4);

         // Humidity clamp and divider operands as magnitudes.
         s19_side_ff.temp <= temp_ff[18];
         s19_side_ff.hum  <= hum_clamp[28:12];
         s19_side_ff.zero <= (adiv18 == '0);
         s19_side_ff.neg  <= num18[63] ^ adiv18[63];
         s19_mn_ff <= num18[63] ? DivW'(-num18) : DivW'(num18);
         if (adiv18 == '0) begin
            s19_md_ff <= DivW'(1);
         end else begin
            s19_md_ff <= adiv18[63] ? DivW'(-adiv18) : DivW'(adiv18);
         end
      end
   end

   // ------------------------------------------------------------------
   // Pressure division.
   // ------------------------------------------------------------------
   logic [DivW-1:0] div_quot;
   side_type        div_side;

   esc_div #(
      .Width (DivW),
      .SideW ($bits(side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pv_ff[19]),
      .in_num    (s19_mn_ff),
      .in_den    (s19_md_ff),
      .in_side   (s19_side_ff),
      .out_valid (div_out_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // Stages after the divider: final pressure terms.
   side_type    side_ff [1:6];
   logic [63:0] q1_p_ff;
   logic [63:0] q2_p_ff, q2_t13_ff;
   mulp_type    q2_u1_ff, q2_bp_ff;
   logic [63:0] q3_p_ff, q3_t13_ff, q3_u1_ff, q3_bp_ff;
   mulp_type    q4_u2_ff;
   logic [63:0] q4_p_ff, q4_bp_ff;
   logic [63:0] q5_p_ff, q5_a_ff, q5_bp_ff;
   logic [63:0] q6_pf_ff;
   logic [63:0] quot64;
   logic signed [63:0] pf_s;
   logic [31:0] press_out;

   assign quot64 = 64'(div_quot);

   always_comb begin
      pf_s = signed'(q6_pf_ff);
      if (side_ff[6].zero || pf_s < 0) begin
         press_out = '0;
      end else if (pf_s[63:32] != '0) begin
         press_out = '1;
      end else begin
         press_out = pf_s[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[1] <= div_side;
         for (int i = 2; i <= 6; i++) side_ff[i] <= side_ff[i-1];

         // Restore the sign of the quotient.
         q1_p_ff <= div_side.neg ? -quot64 : quot64;

         q2_p_ff   <= q1_p_ff;
         q2_t13_ff <= asr(q1_p_ff, 13);
         q2_u1_ff  <= mul_part(p9, asr(q1_p_ff, 13));
         q2_bp_ff  <= mul_part(p8, q1_p_ff);

         q3_p_ff   <= q2_p_ff;
         q3_t13_ff <= q2_t13_ff;
         q3_u1_ff  <= mul_join(q2_u1_ff);
         q3_bp_ff  <= asr(mul_join(q2_bp_ff), 19);

         q4_u2_ff <= mul_part(q3_u1_ff, q3_t13_ff);
         q4_p_ff  <= q3_p_ff;
         q4_bp_ff <= q3_bp_ff;

         q5_a_ff  <= asr(mul_join(q4_u2_ff), 25);
         q5_p_ff  <= q4_p_ff;
         q5_bp_ff <= q4_bp_ff;

         q6_pf_ff <= asr(q5_p_ff + q5_a_ff + q5_bp_ff, 8) + (p7 << 4);

         // Result register.
         rsp_temperature_centi <= signed'(side_ff[6].temp);
         rsp_humidity_q22_10   <= side_ff[6].hum;
         rsp_pressure_q24_8    <= press_out;
      end
   end

   // Humidity never leaves its documented range.
   `ESC_ASSERT_NOW(a_hum_range, clock, reset, rsp_valid_ff,
      rsp_humidity_q22_10 <= 17'd102400, "humidity out of range")

   // An accepted item shows up in the first stage.
   `ESC_ASSERT_NEXT(a_accept_s1, clock, reset, req_valid && req_ready, pv_ff[1],
      "accepted item missing from first stage")

   // A stalled pipeline keeps its items in place.
   `ESC_ASSERT_NEXT(a_stall_hold, clock, reset, !en,
      (pv_ff == $past(pv_ff)) && (qv_ff == $past(qv_ff)), "pipeline moved while stalled")

endmodule

/* dv/env_sensor_compensation_tb.sv */
// ----------------------------------------------------------------------------
// Environmental sensor compensation testbench
// Drives measurement bursts through the compensation pipeline under several
// calibration sets and checks every result against a bit-accurate predictor or a directed reading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module env_sensor_compensation_tb;
   import esc_pkg::*;

   localparam int          RandomItems  = 1450;
   localparam int          CalmItems    = 1300;
   localparam int          DrainCycles  = 100;
   localparam int          WatchdogMax  = 20000;
   localparam logic [2:0]  CsrUnmapped  = 3'd5;

   // Calibration sets used by the directed rows and the random phases.
   typedef enum int {
      CAL_RESET, CAL_TYPICAL, CAL_JITTER, CAL_NO_P1, CAL_ONES, CAL_ZERO,
      CAL_MAXPOS, CAL_MINNEG, CAL_RANDOM
   } cal_kind_type;

   typedef struct packed {
      logic signed [16:0] temp;
      logic [31:0]        press;
      logic [16:0]        hum;
   } reading_type;

   typedef struct packed {
      logic [7:0] pm, pl, px, tm, tl, tx, hm, hl;
   } burst_type;

   typedef struct {
      cal_kind_type cal;
      burst_type    burst;
      bit           typed;
      reading_type  want;
   } row_type;

   logic        clock, reset;
   logic        req_valid, req_ready, rsp_valid, rsp_ready;
   burst_type   req_burst;
   logic signed [16:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_q24_8;
   logic [16:0] rsp_humidity_q22_10;
   logic        psel, penable, pwrite, pready;
   logic [5:0]  paddr;
   logic [63:0] pwdata, prdata;

   // Shadow copy of the calibration registers.
   logic [63:0] cal_temp, cal_press_a, cal_press_b, cal_press_nine, cal_hum;

   reading_type  pending_readings[$];
   int           errors, items_in, items_out, phases;
   bit           calm;
   cal_kind_type cal_now;

   env_sensor_compensation DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_press_msb(req_burst.pm), .req_press_lsb(req_burst.pl),
      .req_press_xlsb(req_burst.px), .req_temp_msb(req_burst.tm),
      .req_temp_lsb(req_burst.tl), .req_temp_xlsb(req_burst.tx),
      .req_hum_msb(req_burst.hm), .req_hum_lsb(req_burst.hl),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_temperature_centi(rsp_temperature_centi),
      .rsp_pressure_q24_8(rsp_pressure_q24_8),
      .rsp_humidity_q22_10(rsp_humidity_q22_10),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Arithmetic shift right of a 64-bit word, rounding toward minus infinity.
   function automatic logic [63:0] sra(input logic [63:0] v, input int unsigned n);
      return $signed(v) >>> n;
   endfunction

   // Integer compensation of one burst with the shadow calibration words.
   function automatic reading_type compensate(input burst_type bu);
      logic [63:0] adc_p, adc_t, adc_h;
      logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] h1, h2, h3, h4, h5, h6;
      logic [63:0] a, b, d, fine, p, num, ma, mb, q;
      logic signed [63:0] s;
      reading_type r;
      adc_p = {44'd0, bu.pm, bu.pl, bu.px[7:4]};
      adc_t = {44'd0, bu.tm, bu.tl, bu.tx[7:4]};
      adc_h = {48'd0, bu.hm, bu.hl};
      t1 = {48'd0, cal_temp[15:0]};
      t2 = 64'($signed(cal_temp[31:16]));
      t3 = 64'($signed(cal_temp[47:32]));
      p1 = {48'd0, cal_press_a[15:0]};
      p2 = 64'($signed(cal_press_a[31:16]));
      p3 = 64'($signed(cal_press_a[47:32]));
      p4 = 64'($signed(cal_press_a[63:48]));
      p5 = 64'($signed(cal_press_b[15:0]));
      p6 = 64'($signed(cal_press_b[31:16]));
      p7 = 64'($signed(cal_press_b[47:32]));
      p8 = 64'($signed(cal_press_b[63:48]));
      p9 = 64'($signed(cal_press_nine[15:0]));
      h1 = {56'd0, cal_hum[7:0]};
      h2 = 64'($signed(cal_hum[23:8]));
      h3 = {56'd0, cal_hum[31:24]};
      h4 = 64'($signed(cal_hum[43:32]));
      h5 = 64'($signed(cal_hum[55:44]));
      h6 = 64'($signed(cal_hum[63:56]));

      // Fine temperature and the saturated temperature result.
      a = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      d = (adc_t >> 4) - t1;
      b = sra(sra(d * d, 12) * t3, 14);
      fine = a + b;
      s = $signed(sra(fine * 64'd5 + 64'd128, 8));
      if (s < -64'sd65536) s = -64'sd65536;
      if (s > 64'sd65535) s = 64'sd65535;
      r.temp = s[16:0];

      // Pressure, with a zero divisor giving zero.
      a = fine - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = sra(a * a * p3, 8) + ((a * p2) << 12);
      a = sra((64'h0000_8000_0000_0000 + a) * p1, 33);
      if (a == 64'd0) begin
         r.press = 32'd0;
      end else begin
         p = 64'd1048576 - adc_p;
         num = ((p << 31) - b) * 64'd3125;
         ma = num[63] ? -num : num;
         mb = a[63] ? -a : a;
         q = ma / mb;
         p = (num[63] ^ a[63]) ? -q : q;
         a = sra(p9 * sra(p, 13) * sra(p, 13), 25);
         b = sra(p8 * p, 19);
         p = sra(p + a + b, 8) + (p7 << 4);
         s = $signed(p);
         if (s < 0) r.press = 32'd0;
         else if (s > 64'sh0_FFFF_FFFF) r.press = 32'hFFFF_FFFF;
         else r.press = s[31:0];
      end

      // Humidity, clamped before the final shift.
      d = fine - 64'd76800;
      a = sra((adc_h << 14) - (h4 << 20) - h5 * d + 64'd16384, 15);
      b = sra(d * h6, 10) * (sra(d * h3, 11) + 64'd32768);
      b = sra(b, 10) + 64'd2097152;
      b = sra(b * h2 + 64'd8192, 14);
      d = a * b;
      d = d - sra(sra(sra(d, 15) * sra(d, 15), 7) * h1, 4);
      s = $signed(d);
      if (s < 0) s = 0;
      if (s > 64'sd419430400) s = 64'sd419430400;
      r.hum = s[28:12];
      return r;
   endfunction

   // One APB write: setup cycle, then access cycle; the shadow follows.
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 3'b000}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         CSR_TEMP_CAL:   cal_temp = value & 64'h0000_FFFF_FFFF_FFFF;
         CSR_PRESS_A:    cal_press_a = value;
         CSR_PRESS_B:    cal_press_b = value;
         CSR_PRESS_NINE: cal_press_nine = value & 64'hFFFF;
         CSR_HUM_CAL:    cal_hum = value;
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // Stop offering items, wait for every expected reading, then settle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Random 16-bit offset in -range..range.
   function automatic logic [15:0] wobble(input logic [15:0] w, input int range);
      return w + 16'($urandom_range(2 * range) - range);
   endfunction

   // Program a whole calibration set; the block must be idle.
   task automatic load_cal(input cal_kind_type kind);
      logic [63:0] tc, pa, pb, pn, hc;
      int j;
      j = (kind == CAL_JITTER) ? 40 : 0;
      tc = {16'd0, wobble(16'hFC18, j), wobble(16'd26435, j * 20),
            wobble(16'd27504, j * 50)};
      pa = {wobble(16'd2855, j * 10), wobble(16'd3024, j * 10),
            wobble(16'hD643, j * 10), wobble(16'd36477, j * 50)};
      pb = {wobble(16'hC6F8, j * 10), wobble(16'hFFF9, 3 * j / 40),
            wobble(16'd15500, j * 10), wobble(16'd140, j)};
      pn = {48'd0, wobble(16'd6000, j * 10)};
      hc = {8'd30 + 8'($urandom_range(j)), 12'd50 + 12'($urandom_range(j)),
            12'd324 + 12'($urandom_range(j)), 8'($urandom_range(j / 4)),
            wobble(16'd362, j), 8'd75 + 8'($urandom_range(j))};
      case (kind)
         CAL_NO_P1: pa[15:0] = 16'd0;
         CAL_ONES: begin
            tc = '1; pa = '1; pb = '1; pn = '1; hc = '1;
         end
         CAL_ZERO: begin
            tc = '0; pa = '0; pb = '0; pn = '0; hc = '0;
         end
         CAL_MAXPOS: begin
            tc = {16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF}; pa = {48'h7FFF_7FFF_7FFF, 16'hFFFF};
            pb = {4{16'h7FFF}}; pn = 64'h7FFF; hc = {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF};
         end
         CAL_MINNEG: begin
            tc = {16'd0, 16'h8000, 16'h8000, 16'h0001}; pa = {48'h8000_8000_8000, 16'h0001};
            pb = {4{16'h8000}}; pn = 64'h8000; hc = {8'h80, 12'h800, 12'h800, 8'h01, 16'h8000, 8'h01};
         end
         CAL_RANDOM: begin
            tc = {$urandom, $urandom}; pa = {$urandom, $urandom};
            pb = {$urandom, $urandom}; pn = {$urandom, $urandom}; hc = {$urandom, $urandom};
         end
         default: ;
      endcase
      csr_write(CSR_TEMP_CAL, tc);
      csr_write(CSR_PRESS_A, pa);
      csr_write(CSR_PRESS_B, pb);
      csr_write(CSR_PRESS_NINE, pn);
      csr_write(CSR_HUM_CAL, hc);
      cal_now = kind;
      phases++;
   endtask

   // Offer one item, with an optional random gap before it.
   task automatic send_burst(input burst_type bu, input bit typed, input reading_type want);
      if (!calm && $urandom_range(5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(14)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_burst <= bu;
      do @(posedge clock); while (!req_ready);
      pending_readings.push_back(typed ? want : compensate(bu));
      items_in++;
   endtask

   // A burst inside the usual sensor range, or fully random at times.
   function automatic burst_type random_burst();
      burst_type bu;
      logic [19:0] ap, at;
      bu = {$urandom, $urandom};
      if ($urandom_range(4) != 0) begin
         ap = 20'($urandom_range(700000, 200000));
         at = 20'($urandom_range(650000, 400000));
         {bu.pm, bu.pl, bu.px[7:4]} = ap;
         {bu.tm, bu.tl, bu.tx[7:4]} = at;
      end
      return bu;
   endfunction

   // Result checking against the oldest expected reading.
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         items_out++;
         if (pending_readings.size() == 0) begin
            errors++;
            $display("%0t: unexpected reading temp %0d press %0d hum %0d", $time,
                     rsp_temperature_centi, rsp_pressure_q24_8, rsp_humidity_q22_10);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_temperature_centi !== want.temp) begin
               errors++;
               $display("%0t: temperature expected %0d actual %0d", $time,
                        want.temp, rsp_temperature_centi);
            end
            if (rsp_pressure_q24_8 !== want.press) begin
               errors++;
               $display("%0t: pressure expected %0d actual %0d", $time,
                        want.press, rsp_pressure_q24_8);
            end
            if (rsp_humidity_q22_10 !== want.hum) begin
               errors++;
               $display("%0t: humidity expected %0d actual %0d", $time,
                        want.hum, rsp_humidity_q22_10);
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WatchdogMax) begin
            $display("%0t: watchdog expired with %0d readings pending", $time,
                     pending_readings.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Result side back-pressure in random bursts, none once the run calms.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm || $urandom_range(3) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(14)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(14)) @(negedge clock);
         end
      end
   end

   // Directed table, then random phases over varied calibration sets.
   initial begin
      row_type rows[$];
      reading_type zero_rd;
      cal_kind_type kind;
      int n;
      reset = 1'b1; req_valid = 1'b0; req_burst = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      cal_temp = '0; cal_press_a = '0; cal_press_b = '0; cal_press_nine = '0; cal_hum = '0;
      errors = 0; items_in = 0; items_out = 0; phases = 0; calm = 1'b0;
      cal_now = CAL_RESET;
      zero_rd = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With all calibration words zero every reading is zero.
      rows.push_back('{CAL_RESET, 64'h0, 1, zero_rd});
      rows.push_back('{CAL_RESET, '1, 1, zero_rd});
      rows.push_back('{CAL_RESET, 64'hAA55_AA55_AA55_AA55, 1, zero_rd});
      rows.push_back('{CAL_RESET, 64'h655A_C07E_ED00_6E8F, 1, zero_rd});
      // Typical calibration: field extremes and ignored low nibbles.
      rows.push_back('{CAL_TYPICAL, 64'h655A_C07E_ED00_6E8F, 0, zero_rd});
      rows.push_back('{CAL_TYPICAL, 64'h655A_CF7E_ED0F_6E8F, 0, zero_rd});
      rows.push_back('{CAL_TYPICAL, 64'h0, 0, zero_rd});
      rows.push_back('{CAL_TYPICAL, '1, 0, zero_rd});
      rows.push_back('{CAL_TYPICAL, 64'h655A_C000_0000_FFFF, 0, zero_rd});
      rows.push_back('{CAL_TYPICAL, 64'h655A_C0FF_FFF0_0000, 0, zero_rd});
      rows.push_back('{CAL_TYPICAL, 64'hFFFF_F07E_ED00_8000, 0, zero_rd});
      // A zero P1 makes the pressure divisor zero.
      rows.push_back('{CAL_NO_P1, 64'h655A_C07E_ED00_6E8F, 1, zero_rd});
      rows.push_back('{CAL_NO_P1, '1, 1, zero_rd});
      // Extreme calibration words drive the saturation and clamp paths.
      rows.push_back('{CAL_ONES, 64'h0, 0, zero_rd});
      rows.push_back('{CAL_ONES, '1, 0, zero_rd});
      rows.push_back('{CAL_MAXPOS, 64'h0, 0, zero_rd});
      rows.push_back('{CAL_MAXPOS, '1, 0, zero_rd});
      rows.push_back('{CAL_MAXPOS, 64'h8000_0080_0000_8000, 0, zero_rd});
      rows.push_back('{CAL_MINNEG, 64'h0, 0, zero_rd});
      rows.push_back('{CAL_MINNEG, '1, 0, zero_rd});
      rows.push_back('{CAL_MINNEG, 64'h8000_0080_0000_8000, 0, zero_rd});

      foreach (rows[i]) begin
         if (rows[i].cal != cal_now) begin
            drain();
            load_cal(rows[i].cal);
            // Only the pressure field is obvious with a zero divisor.
            if (rows[i].cal == CAL_NO_P1) csr_write(CsrUnmapped, '1);
         end
         if (rows[i].typed && rows[i].cal == CAL_NO_P1) begin
            rows[i].want = compensate(rows[i].burst);
            if (rows[i].want.press != 32'd0) rows[i].want.press = 32'd0;
         end
         send_burst(rows[i].burst, rows[i].typed, rows[i].want);
      end

      // Random phases: mostly realistic calibration with jitter.
      n = 0;
      while (n < RandomItems) begin
         drain();
         case ($urandom_range(9))
            0: kind = CAL_RANDOM;
            1: kind = CAL_ONES;
            2: kind = CAL_NO_P1;
            3: kind = ($urandom_range(1) != 0) ? CAL_MAXPOS : CAL_MINNEG;
            4: kind = CAL_TYPICAL;
            default: kind = CAL_JITTER;
         endcase
         load_cal(kind);
         repeat ($urandom_range(200, 80)) begin
            if (n >= RandomItems) break;
            if (n == RandomItems / 2) begin
               // Let the whole pipeline empty before going on.
               @(negedge clock);
               req_valid <= 1'b0;
               while (pending_readings.size() != 0) @(posedge clock);
            end
            calm = (n >= CalmItems);
            send_burst(random_burst(), 0, zero_rd);
            n++;
         end
      end

      drain();
      $display("Covered %0d items and %0d readings over %0d calibration sets,",
               items_in, items_out, phases);
      $display("including zero divisor, saturation and unmapped register writes.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/esc_pkg.sv
design/esc_div.sv
design/env_sensor_compensation.sv
dv/env_sensor_compensation_tb.sv
